>>> rtl/ilpc_pkg.sv
// Shared types and constants of the indicator LED port composer.
// Holds the event record that travels from the front decoder through the
// queue to the back end; no dependencies.
package ilpc_pkg;

   // Stream payload widths
   localparam int REQ_TDATA_W = 40;   // value, red, green, blue
   localparam int REQ_TUSER_W = 5;    // func
   localparam int RSP_TDATA_W = 48;   // port_byte, red, green, blue, zero fill
   localparam int RSP_TUSER_W = 2;    // target

   localparam int FUNC_W  = 5;
   localparam int RAW_W   = 13;
   localparam int LEVEL_W = 12;
   localparam int BYTE_W  = 8;
   localparam int NUM_FLAGS = 11;
   localparam int FLAG_IDX_W = 4;

   // Event queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // Event kinds as classified by the front
   typedef enum logic [2:0] {
      EVT_ALL_OFF,
      EVT_WORK,
      EVT_SPINDLE,
      EVT_RAPID,
      EVT_FLAG,
      EVT_RGB
   } evt_kind_type;

   // Result targets
   typedef enum logic [1:0] {
      TGT_WORK    = 2'd0,
      TGT_SPINDLE = 2'd1,
      TGT_LIMITS  = 2'd2,
      TGT_RGB     = 2'd3
   } tgt_type;

   // Refresh mask bits, in emission order
   localparam int REF_SP  = 0;
   localparam int REF_WS  = 1;
   localparam int REF_LIM = 2;

   // One status channel after saturation
   typedef struct packed {
      logic               keep;
      logic [LEVEL_W-1:0] level;
   } lvl_type;

   // One classified event
   typedef struct packed {
      evt_kind_type          kind;
      logic [2:0]            sel;
      logic [FLAG_IDX_W-1:0] flag;
      logic                  value;
      logic [2:0]            refresh;
      lvl_type [2:0]         lvl;      // 0 red, 1 green, 2 blue
   } evt_type;

endpackage

>>> rtl/indicator_led_port_composer_core.sv
// Indicator LED port composer: composes active-low expander port bytes and
// RGB status levels from panel events, one request beat per cycle accepted
// while the queue has room into a four-entry event queue; the back end
// retires an event per cycle that makes at most one write while the output
// is not stalled, and an all-off event holds it until its writes (up to
// three) are out. A result passes the queue entry, the pending-write slot
// and the output register. Event ids 25 to 31 are dropped, a port write goes
// out only when the byte changed, and an RGB update only when a level changed.
// Depends on ilpc_pkg, ilpc_front, ilpc_queue and ilpc_back.
module indicator_led_port_composer_core #(
   parameter int PWM_MAX = 4095
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // value [0], red_level [13:1], green_level [26:14], blue_level [39:27]
   input  logic [ilpc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func [4:0]
   input  logic [ilpc_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // port_byte [7:0], out_red [19:8], out_green [31:20], out_blue [43:32], zeros
   output logic [ilpc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // target [1:0]
   output logic [ilpc_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast
);
   import ilpc_pkg::*;

   logic    queue_full;
   logic    push;
   evt_type push_evt;
   logic    head_valid;
   evt_type head_evt;
   logic    pop;

   ilpc_front #(
      .PWM_MAX (PWM_MAX)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_evt   (push_evt)
   );

   ilpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_evt   (push_evt),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_evt   (head_evt),
      .pop        (pop)
   );

   ilpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .evt_valid  (head_valid),
      .evt        (head_evt),
      .evt_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/ilpc_front.sv
// Front decoder of the indicator LED port composer: accepts request beats,
// classifies func into an event record and drops unused ids.
// Depends on ilpc_pkg.
module ilpc_front #(
   parameter int PWM_MAX = 4095
) (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ilpc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [ilpc_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             queue_full,
   output logic                             push,
   output ilpc_pkg::evt_type                push_evt
);
   import ilpc_pkg::*;

   localparam logic [16:0] PwmMaxW = 17'(PWM_MAX);

   logic [FUNC_W-1:0] func;
   logic              evt_ok;
   logic [RAW_W-1:0]  raw [3];
   evt_type           evt;

   assign func   = req_tuser;
   assign raw[0] = req_tdata[13:1];
   assign raw[1] = req_tdata[26:14];
   assign raw[2] = req_tdata[39:27];

   // Classify the event id
   always_comb begin
      evt         = '0;
      evt.kind    = EVT_ALL_OFF;
      evt.value   = req_tdata[0];
      evt_ok      = 1'b1;
      priority if (func == 5'd0) begin
         evt.kind    = EVT_ALL_OFF;
         evt.refresh = 3'b111;
      end else if (func <= 5'd6) begin
         evt.kind             = EVT_WORK;
         evt.sel              = 3'(func - 5'd1);
         evt.refresh[REF_WS]  = 1'b1;
      end else if (func <= 5'd9) begin
         evt.kind             = EVT_SPINDLE;
         evt.sel              = 3'(func - 5'd7);
         evt.refresh[REF_SP]  = 1'b1;
      end else if (func <= 5'd15) begin
         evt.kind = EVT_FLAG;
         evt.flag = FLAG_IDX_W'(func - 5'd10);
         // unlock and home refresh the work-set port, the rest the spindle port
         if (func == 5'd11 || func == 5'd12) begin
            evt.refresh[REF_WS] = 1'b1;
         end else begin
            evt.refresh[REF_SP] = 1'b1;
         end
      end else if (func <= 5'd18) begin
         evt.kind             = EVT_RAPID;
         evt.sel              = 3'(func - 5'd16);
         evt.refresh[REF_LIM] = 1'b1;
      end else if (func <= 5'd23) begin
         evt.kind             = EVT_FLAG;
         evt.flag             = FLAG_IDX_W'(func - 5'd13);
         evt.refresh[REF_LIM] = 1'b1;
      end else if (func == 5'd24) begin
         evt.kind = EVT_RGB;
      end else begin
         evt_ok = 1'b0;
      end

      // Saturate levels; any negative level keeps its channel
      for (int i = 0; i < 3; i++) begin
         evt.lvl[i].keep = raw[i][RAW_W-1];
         if ({5'b0, raw[i][LEVEL_W-1:0]} > PwmMaxW) begin
            evt.lvl[i].level = PwmMaxW[LEVEL_W-1:0];
         end else begin
            evt.lvl[i].level = raw[i][LEVEL_W-1:0];
         end
      end
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full && evt_ok;
   assign push_evt   = evt;

endmodule

>>> rtl/ilpc_queue.sv
// Short event queue between the front decoder and the back end.
// Depends on ilpc_pkg for the event record and depth.
module ilpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ilpc_pkg::evt_type push_evt,
   output logic              full,
   output logic              head_valid,
   output ilpc_pkg::evt_type head_evt,
   input  logic              pop
);
   import ilpc_pkg::*;

   evt_type              mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_evt   = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_evt;
      end
   end

endmodule

>>> rtl/ilpc_back.sv
// Back end of the indicator LED port composer: applies events to the
// selections, flags, shadows and levels, and emits port writes in order.
// Depends on ilpc_pkg.
module ilpc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             evt_valid,
   input  ilpc_pkg::evt_type                evt,
   output logic                             evt_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ilpc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [ilpc_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast
);
   import ilpc_pkg::*;

   localparam logic [2:0] WS_NONE  = 3'd7;
   localparam logic [1:0] SEL_NONE = 2'd3;

   localparam int FL_RESET  = 0;
   localparam int FL_UNLOCK = 1;
   localparam int FL_HOME   = 2;
   localparam int FL_RESUME = 4;
   localparam int FL_FEED   = 5;
   localparam int FL_XLIM   = 6;
   localparam int FL_YLIM   = 7;
   localparam int FL_ZLIM   = 8;
   localparam int FL_PROBE  = 9;
   localparam int FL_JOG    = 10;

   localparam logic [7:0] WS_MASK [6] = '{8'hFD, 8'hFE, 8'h7F, 8'hBF, 8'hDF, 8'hEF};
   localparam logic [7:0] SP_MASK [3] = '{8'hBF, 8'hDF, 8'hEF};
   localparam logic [7:0] RP_MASK [3] = '{8'h7F, 8'hBF, 8'hDF};

   function automatic logic [7:0] build_ws(logic [2:0] sel, logic [NUM_FLAGS-1:0] fl);
      logic [7:0] b;
      b = 8'hFF;
      if (sel < 3'd6) b = b & WS_MASK[sel];
      if (fl[FL_HOME])   b = b & 8'hF7;
      if (fl[FL_UNLOCK]) b = b & 8'hFB;
      return b;
   endfunction

   function automatic logic [7:0] build_sp(logic [1:0] sel, logic [NUM_FLAGS-1:0] fl);
      logic [7:0] b;
      b = 8'hFF;
      if (sel < 2'd3) b = b & SP_MASK[sel];
      if (fl[FL_RESET])  b = b & 8'hF7;
      if (fl[FL_RESUME]) b = b & 8'hFD;
      if (fl[FL_FEED])   b = b & 8'hFB;
      return b;
   endfunction

   function automatic logic [7:0] build_lim(logic [1:0] sel, logic [NUM_FLAGS-1:0] fl);
      logic [7:0] b;
      b = 8'hFF;
      if (sel < 2'd3) b = b & RP_MASK[sel];
      if (fl[FL_XLIM])  b = b & 8'hFE;
      if (fl[FL_YLIM])  b = b & 8'hFD;
      if (fl[FL_ZLIM])  b = b & 8'hFB;
      if (fl[FL_PROBE]) b = b & 8'hF7;
      if (fl[FL_JOG])   b = b & 8'hEF;
      return b;
   endfunction

   // Architectural state
   logic [2:0]           work_sel_ff, work_sel_in;
   logic [1:0]           spin_sel_ff, spin_sel_in;
   logic [1:0]           rapid_sel_ff, rapid_sel_in;
   logic [NUM_FLAGS-1:0] flags_ff, flags_in;
   logic [BYTE_W-1:0]    shadow_ff [3];
   logic [BYTE_W-1:0]    shadow_in [3];
   logic [LEVEL_W-1:0]   level_ff [3];
   logic [LEVEL_W-1:0]   level_in [3];

   // Pending writes: slot 0 spindle or RGB, slot 1 work set, slot 2 limits
   logic [2:0]           slot_valid_ff, slot_valid_in;
   logic                 slot0_rgb_ff, slot0_rgb_in;
   logic [BYTE_W-1:0]    slot_byte_ff [3];
   logic [BYTE_W-1:0]    slot_byte_in [3];

   // Output register
   logic                 out_valid_ff, out_valid_in;
   tgt_type              out_tgt_ff, out_tgt_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic [LEVEL_W-1:0]   out_lvl_ff [3];
   logic [LEVEL_W-1:0]   out_lvl_in [3];
   logic                 out_last_ff, out_last_in;

   logic                 out_free;
   logic                 emit;
   logic [2:0]           pick;
   logic [2:0]           remaining;
   logic [BYTE_W-1:0]    new_byte [3];
   logic                 rgb_change;

   // Pick the first pending write and see what stays behind
   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      emit     = out_free && (slot_valid_ff != '0);
      priority if (slot_valid_ff[0]) begin
         pick = 3'b001;
      end else if (slot_valid_ff[1]) begin
         pick = 3'b010;
      end else begin
         pick = 3'b100;
      end
      remaining = emit ? (slot_valid_ff & ~pick) : slot_valid_ff;
      evt_pop   = evt_valid && (remaining == '0);
   end

   // Apply the popped event and rebuild the affected ports
   always_comb begin
      work_sel_in  = work_sel_ff;
      spin_sel_in  = spin_sel_ff;
      rapid_sel_in = rapid_sel_ff;
      flags_in     = flags_ff;
      shadow_in    = shadow_ff;
      level_in     = level_ff;
      slot_valid_in = remaining;
      slot0_rgb_in  = slot0_rgb_ff;
      slot_byte_in  = slot_byte_ff;
      rgb_change    = 1'b0;

      if (evt_pop) begin
         unique case (evt.kind)
            EVT_ALL_OFF: begin
               work_sel_in  = WS_NONE;
               spin_sel_in  = SEL_NONE;
               rapid_sel_in = SEL_NONE;
               flags_in     = '0;
            end
            EVT_WORK:    work_sel_in  = evt.sel;
            EVT_SPINDLE: spin_sel_in  = evt.sel[1:0];
            EVT_RAPID:   rapid_sel_in = evt.sel[1:0];
            EVT_FLAG: begin
               for (int i = 0; i < NUM_FLAGS; i++) begin
                  if (evt.flag == FLAG_IDX_W'(i)) flags_in[i] = evt.value;
               end
            end
            EVT_RGB: begin
               for (int i = 0; i < 3; i++) begin
                  if (!evt.lvl[i].keep && evt.lvl[i].level != level_ff[i]) begin
                     level_in[i] = evt.lvl[i].level;
                     rgb_change  = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      new_byte[REF_SP]  = build_sp(spin_sel_in, flags_in);
      new_byte[REF_WS]  = build_ws(work_sel_in, flags_in);
      new_byte[REF_LIM] = build_lim(rapid_sel_in, flags_in);

      if (evt_pop) begin
         slot_valid_in = '0;
         slot0_rgb_in  = 1'b0;
         if (evt.kind == EVT_RGB) begin
            slot_valid_in[0] = rgb_change;
            slot0_rgb_in     = 1'b1;
            slot_byte_in[0]  = '0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (evt.refresh[i] && new_byte[i] != shadow_ff[i]) begin
                  slot_valid_in[i] = 1'b1;
                  slot_byte_in[i]  = new_byte[i];
                  shadow_in[i]     = new_byte[i];
               end
            end
         end
      end
   end

   // Load the output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_tgt_in   = out_tgt_ff;
      out_byte_in  = out_byte_ff;
      out_lvl_in   = out_lvl_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = emit;
      end
      if (emit) begin
         out_last_in = (remaining == '0);
         out_lvl_in  = '{default: '0};
         if (pick[0] && slot0_rgb_ff) begin
            out_tgt_in  = TGT_RGB;
            out_byte_in = '0;
            out_lvl_in  = level_ff;
         end else if (pick[0]) begin
            out_tgt_in  = TGT_SPINDLE;
            out_byte_in = slot_byte_ff[0];
         end else if (pick[1]) begin
            out_tgt_in  = TGT_WORK;
            out_byte_in = slot_byte_ff[1];
         end else begin
            out_tgt_in  = TGT_LIMITS;
            out_byte_in = slot_byte_ff[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_sel_ff   <= WS_NONE;
         spin_sel_ff   <= SEL_NONE;
         rapid_sel_ff  <= SEL_NONE;
         flags_ff      <= '0;
         shadow_ff     <= '{default: 8'hFF};
         level_ff      <= '{default: '0};
         slot_valid_ff <= '0;
         slot0_rgb_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_sel_ff   <= work_sel_in;
         spin_sel_ff   <= spin_sel_in;
         rapid_sel_ff  <= rapid_sel_in;
         flags_ff      <= flags_in;
         shadow_ff     <= shadow_in;
         level_ff      <= level_in;
         slot_valid_ff <= slot_valid_in;
         slot0_rgb_ff  <= slot0_rgb_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_byte_ff <= slot_byte_in;
      out_tgt_ff   <= out_tgt_in;
      out_byte_ff  <= out_byte_in;
      out_lvl_ff   <= out_lvl_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_tgt_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0, out_lvl_ff[2], out_lvl_ff[1], out_lvl_ff[0], out_byte_ff};

endmodule
